// ----- rtl/core/ulog_pkg.sv -----
// Shared constants, operation codes and ring pointer helper for the unstable log table.
package ulog_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int IDX_W      = 64;
  localparam int TERM_W     = 64;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(RING_DEPTH);

  localparam logic [2:0] FN_APPEND      = 3'd0;
  localparam logic [2:0] FN_STABLE      = 3'd1;
  localparam int         FN_W           = 3;
  localparam logic [2:0] FN_SNAP_STABLE = 3'd2;
  localparam logic [2:0] FN_RESTORE     = 3'd3;
  localparam logic [2:0] FN_QUERY       = 3'd4;

  // Ring position of head + off, with head below the depth and off at most the depth.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ----- rtl/core/ulog_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module ulog_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/consensus_unstable_log_table_core.sv -----
// Top level of the unstable log table: operation sequencer around the term ring RAM.
//
//   port group   direction   handshake            payload
//   in_*         input       in_valid/in_ready    in_func, in_entry_index, in_entry_term
//   out_*        output      out_valid/out_ready  out_found .. out_status
//
// An operation steps through accept, index subtract, execute and result load;
// its result word is registered in the load step. A term query or stable-to
// that reads the ring adds a read step for the registered read port.
// rst_n clears the pointers, offset and snapshot; ring contents are not cleared.
// A new word is accepted while the last result still waits; a stalled result
// holds the sequencer in its load step until out_ready.
module consensus_unstable_log_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ulog_pkg::FN_W-1:0]     in_func,
  input  logic [ulog_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [ulog_pkg::TERM_W-1:0]   in_entry_term,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [ulog_pkg::TERM_W-1:0]   out_found_term,
  output logic [ulog_pkg::IDX_W-1:0]    out_first_index,
  output logic                          out_has_first,
  output logic [ulog_pkg::IDX_W-1:0]    out_last_index,
  output logic                          out_has_last,
  output logic                          out_status
);

  import ulog_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_CALC, ST_EXEC, ST_READ, ST_OUT} state_t;

  state_t              state_r, state_nxt;
  logic [FN_W-1:0]     func_r, func_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [TERM_W-1:0]   term_r, term_nxt;
  logic [IDX_W-1:0]    diff_r, diff_nxt;
  logic                borrow_r, borrow_nxt;
  logic                wrap_r, wrap_nxt;
  logic                found_r, found_nxt;
  logic [TERM_W-1:0]   found_term_r, found_term_nxt;
  logic                dropped_r, dropped_nxt;

  logic [IDX_W-1:0]    base_r, base_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                snap_valid_r, snap_valid_nxt;
  logic [IDX_W-1:0]    snap_index_r, snap_index_nxt;
  logic [TERM_W-1:0]   snap_term_r, snap_term_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [TERM_W-1:0]   out_found_term_r, out_found_term_nxt;
  logic [IDX_W-1:0]    out_first_r, out_first_nxt;
  logic                out_has_first_r, out_has_first_nxt;
  logic [IDX_W-1:0]    out_last_r, out_last_nxt;
  logic                out_has_last_r, out_has_last_nxt;
  logic                out_status_r, out_status_nxt;

  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr;
  logic [PTR_W-1:0]    ram_raddr;
  logic [TERM_W-1:0]   ram_rdata;

  logic [CNT_W-1:0]    diff_lo;
  logic                eq_cnt;
  logic                lt_cnt;
  logic [CNT_W-1:0]    drop_n;
  logic [IDX_W:0]      tail_sum;

  ulog_ram #(
    .WIDTH (TERM_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (term_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign diff_lo  = diff_r[CNT_W-1:0];
  assign eq_cnt   = (diff_r == IDX_W'(count_r));
  assign lt_cnt   = (diff_r[IDX_W-1:CNT_W] == '0) && (diff_lo < count_r);
  assign drop_n   = diff_lo + CNT_W'(1);
  assign tail_sum = {1'b0, base_r} + (IDX_W + 1)'(count_r - CNT_W'(1));

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_found_term  = out_found_term_r;
  assign out_first_index = out_first_r;
  assign out_has_first   = out_has_first_r;
  assign out_last_index  = out_last_r;
  assign out_has_last    = out_has_last_r;
  assign out_status      = out_status_r;

  always_comb begin
    state_nxt          = state_r;
    func_nxt           = func_r;
    idx_nxt            = idx_r;
    term_nxt           = term_r;
    diff_nxt           = diff_r;
    borrow_nxt         = borrow_r;
    wrap_nxt           = wrap_r;
    found_nxt          = found_r;
    found_term_nxt     = found_term_r;
    dropped_nxt        = dropped_r;
    base_nxt           = base_r;
    head_nxt           = head_r;
    count_nxt          = count_r;
    snap_valid_nxt     = snap_valid_r;
    snap_index_nxt     = snap_index_r;
    snap_term_nxt      = snap_term_r;
    out_valid_nxt      = out_valid_r;
    out_found_nxt      = out_found_r;
    out_found_term_nxt = out_found_term_r;
    out_first_nxt      = out_first_r;
    out_has_first_nxt  = out_has_first_r;
    out_last_nxt       = out_last_r;
    out_has_last_nxt   = out_has_last_r;
    out_status_nxt     = out_status_r;
    ram_we             = 1'b0;
    ram_waddr          = '0;
    ram_raddr          = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          idx_nxt   = in_entry_index;
          term_nxt  = in_entry_term;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        // borrow set means the index lies below the offset
        {borrow_nxt, diff_nxt} = {1'b0, idx_r} - {1'b0, base_r};
        // last index wrapped past zero: no index at or above the offset is found
        wrap_nxt       = (count_r != '0) && tail_sum[IDX_W];
        found_nxt      = 1'b0;
        found_term_nxt = '0;
        dropped_nxt    = 1'b0;
        state_nxt      = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_OUT;
        case (func_r)
          FN_APPEND: begin
            if (eq_cnt) begin
              if (count_r == DEPTH_CNT) begin
                dropped_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(head_r, count_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end else if (borrow_r || (diff_r == '0)) begin
              // replace the ring with this single word
              ram_we    = 1'b1;
              ram_waddr = '0;
              base_nxt  = idx_r;
              head_nxt  = '0;
              count_nxt = CNT_W'(1);
            end else if (lt_cnt) begin
              // truncate just before the index, then add
              ram_we    = 1'b1;
              ram_waddr = ring_add(head_r, diff_lo);
              count_nxt = drop_n;
            end
          end
          FN_STABLE, FN_QUERY: begin
            if (!borrow_r && lt_cnt && !wrap_r) begin
              ram_raddr = ring_add(head_r, diff_lo);
              state_nxt = ST_READ;
            end else if ((func_r == FN_QUERY) && borrow_r && snap_valid_r &&
                         (snap_index_r == idx_r)) begin
              found_nxt      = 1'b1;
              found_term_nxt = snap_term_r;
            end
          end
          FN_SNAP_STABLE: begin
            if (snap_valid_r && (snap_index_r == idx_r)) begin
              snap_valid_nxt = 1'b0;
            end
          end
          FN_RESTORE: begin
            base_nxt       = idx_r + IDX_W'(1);
            head_nxt       = '0;
            count_nxt      = '0;
            snap_valid_nxt = 1'b1;
            snap_index_nxt = idx_r;
            snap_term_nxt  = term_r;
          end
          default: ;
        endcase
      end
      ST_READ: begin
        state_nxt = ST_OUT;
        if (func_r == FN_QUERY) begin
          found_nxt      = 1'b1;
          found_term_nxt = ram_rdata;
        end else if (ram_rdata == term_r) begin
          // drop the front through the matching index
          head_nxt  = ring_add(head_r, drop_n);
          count_nxt = count_r - drop_n;
          base_nxt  = idx_r + IDX_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_found_nxt      = found_r;
          out_found_term_nxt = found_term_r;
          out_has_first_nxt  = snap_valid_r;
          out_first_nxt      = snap_valid_r ? snap_index_r + IDX_W'(1) : '0;
          out_has_last_nxt   = (count_r != '0) || snap_valid_r;
          if (count_r != '0) begin
            out_last_nxt = base_r + IDX_W'(count_r) - IDX_W'(1);
          end else if (snap_valid_r) begin
            out_last_nxt = snap_index_r;
          end else begin
            out_last_nxt = '0;
          end
          out_status_nxt = dropped_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= '0;
      head_r       <= '0;
      count_r      <= '0;
      snap_valid_r <= 1'b0;
      snap_index_r <= '0;
      snap_term_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      snap_valid_r <= snap_valid_nxt;
      snap_index_r <= snap_index_nxt;
      snap_term_r  <= snap_term_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    func_r           <= func_nxt;
    idx_r            <= idx_nxt;
    term_r           <= term_nxt;
    diff_r           <= diff_nxt;
    borrow_r         <= borrow_nxt;
    wrap_r           <= wrap_nxt;
    found_r          <= found_nxt;
    found_term_r     <= found_term_nxt;
    dropped_r        <= dropped_nxt;
    out_found_r      <= out_found_nxt;
    out_found_term_r <= out_found_term_nxt;
    out_first_r      <= out_first_nxt;
    out_has_first_r  <= out_has_first_nxt;
    out_last_r       <= out_last_nxt;
    out_has_last_r   <= out_has_last_nxt;
    out_status_r     <= out_status_nxt;
  end

endmodule

// ----- test/ulog_table_checker.sv -----
`timescale 1ns / 1ps
// Checker for the unstable log table: predicts each operation's report and compares it.
module ulog_table_checker
  import ulog_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [FN_W-1:0]   in_func,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [TERM_W-1:0] in_entry_term,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_found,
  input  logic [TERM_W-1:0] out_found_term,
  input  logic [IDX_W-1:0]  out_first_index,
  input  logic              out_has_first,
  input  logic [IDX_W-1:0]  out_last_index,
  input  logic              out_has_last,
  input  logic              out_status,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic              found;
    logic [TERM_W-1:0] found_term;
    logic [IDX_W-1:0]  first_index;
    logic              has_first;
    logic [IDX_W-1:0]  last_index;
    logic              has_last;
    logic              status;
  } log_report_t;

  logic [TERM_W-1:0] term_mem [RING_DEPTH];
  logic [IDX_W-1:0]  lo_index;
  logic [PTR_W-1:0]  head_pos;
  logic [CNT_W-1:0]  held_cnt;
  logic              snap_v;
  logic [IDX_W-1:0]  snap_idx;
  logic [TERM_W-1:0] snap_trm;
  log_report_t       report_q [$];

  initial fail_count = 0;

  function automatic logic [PTR_W-1:0] slot_of(input logic [CNT_W-1:0] rel);
    return PTR_W'((int'(head_pos) + int'(rel)) % RING_DEPTH);
  endfunction

  // Last held index: tail of the entries, else the snapshot.
  function automatic logic tail_index(output logic [IDX_W-1:0] last);
    if (held_cnt != '0) begin
      last = lo_index + IDX_W'(held_cnt) - IDX_W'(1);
      return 1'b1;
    end
    if (snap_v) begin
      last = snap_idx;
      return 1'b1;
    end
    last = '0;
    return 1'b0;
  endfunction

  function automatic logic lookup_term(input logic [IDX_W-1:0] idx,
                                       output logic [TERM_W-1:0] trm);
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] rel;
    trm = '0;
    if (idx < lo_index) begin
      if (snap_v && snap_idx == idx) begin
        trm = snap_trm;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!tail_index(last) || idx > last) return 1'b0;
    rel = idx - lo_index;
    if (rel >= IDX_W'(held_cnt)) return 1'b0;
    trm = term_mem[slot_of(CNT_W'(rel))];
    return 1'b1;
  endfunction

  function automatic logic push_term(input logic [TERM_W-1:0] trm);
    if (held_cnt >= CNT_W'(RING_DEPTH)) return 1'b0;
    term_mem[slot_of(held_cnt)] = trm;
    held_cnt = held_cnt + CNT_W'(1);
    return 1'b1;
  endfunction

  // Returns 0 when the entry is dropped on a full ring.
  function automatic logic append_term(input logic [IDX_W-1:0] idx,
                                       input logic [TERM_W-1:0] trm);
    logic [IDX_W-1:0] next_idx;
    logic [IDX_W-1:0] rel;
    next_idx = lo_index + IDX_W'(held_cnt);
    if (idx == next_idx) return push_term(trm);
    if (idx <= lo_index) begin
      lo_index = idx;
      head_pos = '0;
      held_cnt = '0;
      return push_term(trm);
    end
    rel = idx - lo_index;
    if (rel < IDX_W'(held_cnt)) begin
      held_cnt = CNT_W'(rel);
      return push_term(trm);
    end
    // gap: ignore
    return 1'b1;
  endfunction

  function automatic void settle_to(input logic [IDX_W-1:0] idx,
                                    input logic [TERM_W-1:0] trm);
    logic [TERM_W-1:0] held_trm;
    logic [IDX_W-1:0]  drop_n;
    if (!lookup_term(idx, held_trm)) return;
    if (held_trm == trm && idx >= lo_index) begin
      drop_n = idx - lo_index + IDX_W'(1);
      if (drop_n > IDX_W'(held_cnt)) return;
      head_pos = slot_of(CNT_W'(drop_n));
      held_cnt = held_cnt - CNT_W'(drop_n);
      lo_index = idx + IDX_W'(1);
    end
  endfunction

  function automatic log_report_t apply_op(input logic [FN_W-1:0] f,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [TERM_W-1:0] trm);
    log_report_t       rpt;
    logic [IDX_W-1:0]  last;
    logic [TERM_W-1:0] hit_trm;
    rpt = '0;
    case (f)
      FN_APPEND: begin
        rpt.status = !append_term(idx, trm);
      end
      FN_STABLE: begin
        settle_to(idx, trm);
      end
      FN_SNAP_STABLE: begin
        if (snap_v && snap_idx == idx) snap_v = 1'b0;
      end
      FN_RESTORE: begin
        lo_index = idx + IDX_W'(1);
        head_pos = '0;
        held_cnt = '0;
        snap_v   = 1'b1;
        snap_idx = idx;
        snap_trm = trm;
      end
      FN_QUERY: begin
        rpt.found      = lookup_term(idx, hit_trm);
        rpt.found_term = rpt.found ? hit_trm : '0;
      end
      default: ;
    endcase
    rpt.has_first   = snap_v;
    rpt.first_index = snap_v ? snap_idx + IDX_W'(1) : '0;
    rpt.has_last    = tail_index(last);
    rpt.last_index  = last;
    return rpt;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    log_report_t want;
    if (!rst_n) begin
      lo_index = '0;
      head_pos = '0;
      held_cnt = '0;
      snap_v   = 1'b0;
      snap_idx = '0;
      snap_trm = '0;
      report_q.delete();
      pending_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("result word with no operation outstanding");
          fail_count++;
        end else begin
          want = report_q.pop_front();
          check_field("found", 64'(want.found), 64'(out_found));
          check_field("found_term", want.found_term, out_found_term);
          check_field("first_index", want.first_index, out_first_index);
          check_field("has_first", 64'(want.has_first), 64'(out_has_first));
          check_field("last_index", want.last_index, out_last_index);
          check_field("has_last", 64'(want.has_last), 64'(out_has_last));
          check_field("status", 64'(want.status), 64'(out_status));
        end
      end
      if (in_valid && in_ready) begin
        report_q.push_back(apply_op(in_func, in_entry_index, in_entry_term));
      end
      pending_count <= report_q.size();
    end
  end

endmodule

// ----- test/tb_consensus_unstable_log_table_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the unstable log table: clock, reset, operation stimulus and verdict.
module tb_consensus_unstable_log_table_core;
  import ulog_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_OPS  = 1100;
  localparam int FILL_RUN    = 270;
  localparam int TAIL_CYCLES = 20;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [FN_W-1:0]   in_func        = '0;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [TERM_W-1:0] in_entry_term  = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              out_found;
  logic [TERM_W-1:0] out_found_term;
  logic [IDX_W-1:0]  out_first_index;
  logic              out_has_first;
  logic [IDX_W-1:0]  out_last_index;
  logic              out_has_last;
  logic              out_status;

  int tx_idle_pct  = 19;
  int rx_idle_pct  = 81;
  int quiet_cycles = 0;
  int fail_count;
  int pending_count;

  // Rough view of the log, used only to steer stimulus toward well-formed sequences.
  logic [IDX_W-1:0]  sh_base     = '0;
  int                sh_held     = 0;
  int                sh_run      = 0; // first entry of the trailing run with sh_term
  logic              sh_snap_v   = 1'b0;
  logic [IDX_W-1:0]  sh_snap_idx = '0;
  logic [TERM_W-1:0] sh_term     = '0;

  consensus_unstable_log_table_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_entry_term   (in_entry_term),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_found_term  (out_found_term),
    .out_first_index (out_first_index),
    .out_has_first   (out_has_first),
    .out_last_index  (out_last_index),
    .out_has_last    (out_has_last),
    .out_status      (out_status)
  );

  ulog_table_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_entry_term   (in_entry_term),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_found_term  (out_found_term),
    .out_first_index (out_first_index),
    .out_has_first   (out_has_first),
    .out_last_index  (out_last_index),
    .out_has_last    (out_has_last),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void track_op(input logic [FN_W-1:0] f, input logic [IDX_W-1:0] idx,
                                   input logic [TERM_W-1:0] trm);
    logic [IDX_W-1:0] rel;
    rel = idx - sh_base;
    case (f)
      FN_APPEND: begin
        if (idx == sh_base + IDX_W'(sh_held)) begin
          if (sh_held < RING_DEPTH) begin
            if (trm != sh_term) sh_run = sh_held + 1;
            sh_held++;
          end
        end else if (idx <= sh_base) begin
          sh_base = idx;
          sh_held = 1;
          sh_run  = (trm == sh_term) ? 0 : 1;
        end else if (rel < IDX_W'(sh_held)) begin
          sh_held = int'(rel) + 1;
          if (trm != sh_term) sh_run = sh_held;
          else if (sh_run > int'(rel)) sh_run = int'(rel);
        end
      end
      FN_STABLE: begin
        if (trm == sh_term && rel >= IDX_W'(sh_run) && rel < IDX_W'(sh_held)) begin
          sh_held = sh_held - int'(rel) - 1;
          sh_run  = 0;
          sh_base = idx + IDX_W'(1);
        end
      end
      FN_SNAP_STABLE: begin
        if (sh_snap_v && sh_snap_idx == idx) sh_snap_v = 1'b0;
      end
      FN_RESTORE: begin
        sh_base     = idx + IDX_W'(1);
        sh_held     = 0;
        sh_run      = 0;
        sh_snap_v   = 1'b1;
        sh_snap_idx = idx;
        sh_term     = trm;
      end
      default: ;
    endcase
  endfunction

  // Hold the word until accepted; valid stays up across back-to-back words.
  task automatic send_op(input logic [FN_W-1:0] f, input logic [IDX_W-1:0] idx,
                         input logic [TERM_W-1:0] trm);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_entry_index <= idx;
    in_entry_term  <= trm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_op(f, idx, trm);
  endtask

  task automatic fill_ring();
    repeat (FILL_RUN) send_op(FN_APPEND, sh_base + IDX_W'(sh_held), sh_term);
  endtask

  task automatic random_op();
    int                pick;
    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  idx;
    logic [TERM_W-1:0] trm;
    logic [FN_W-1:0]   f;
    pick     = $urandom_range(99);
    next_idx = sh_base + IDX_W'(sh_held);
    if (pick < 40) begin
      send_op(FN_APPEND, next_idx, sh_term);
    end else if (pick < 47) begin
      // rewrite the tail, often under a new term
      if ($urandom_range(1) == 1) begin
        sh_term = sh_term + TERM_W'($urandom_range(4, 1));
        sh_run  = sh_held;
      end
      idx = sh_base - IDX_W'(2) + IDX_W'($urandom_range(sh_held + 1));
      send_op(FN_APPEND, idx, sh_term);
    end else if (pick < 51) begin
      send_op(FN_APPEND, next_idx + IDX_W'($urandom_range(8, 1)), {$urandom, $urandom});
    end else if (pick < 61) begin
      if (sh_held > sh_run) idx = sh_base + IDX_W'($urandom_range(sh_held - 1, sh_run));
      else idx = sh_base;
      send_op(FN_STABLE, idx, sh_term);
    end else if (pick < 65) begin
      idx = sh_base - IDX_W'(1) + IDX_W'($urandom_range(sh_held + 1));
      trm = ($urandom_range(1) == 1) ? sh_term ^ (TERM_W'(1) << $urandom_range(63))
                                     : {$urandom, $urandom};
      send_op(FN_STABLE, idx, trm);
    end else if (pick < 70) begin
      send_op(FN_SNAP_STABLE, sh_snap_idx + IDX_W'($urandom_range(3) == 0), {$urandom, $urandom});
    end else if (pick < 74) begin
      if ($urandom_range(3) == 0) idx = {$urandom, $urandom};
      else idx = next_idx - IDX_W'(2) + IDX_W'($urandom_range(4));
      if ($urandom_range(4) == 0) trm = {$urandom, $urandom};
      else trm = sh_term + TERM_W'($urandom_range(2));
      send_op(FN_RESTORE, idx, trm);
    end else if (pick < 92) begin
      if ($urandom_range(4) == 0) idx = sh_snap_idx;
      else idx = sh_base - IDX_W'(3) + IDX_W'($urandom_range(sh_held + 5));
      send_op(FN_QUERY, idx, {$urandom, $urandom});
    end else if (pick < 96) begin
      f = FN_W'($urandom_range(int'(FN_QUERY)));
      send_op(f, {$urandom, $urandom}, {$urandom, $urandom});
    end else begin
      f = FN_W'($urandom_range((1 << FN_W) - 1, int'(FN_QUERY) + 1));
      send_op(f, {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    int sent;
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table
    send_op(FN_QUERY, '0, '0);
    send_op(FN_SNAP_STABLE, '0, '0);
    send_op(FN_APPEND, IDX_W'(5), TERM_W'(7));
    // build, truncate, settle
    send_op(FN_APPEND, IDX_W'(0), '1);
    send_op(FN_APPEND, IDX_W'(1), '0);
    send_op(FN_APPEND, IDX_W'(2), 64'h8000_0000_0000_0000);
    send_op(FN_QUERY, IDX_W'(1), '0);
    send_op(FN_APPEND, IDX_W'(1), TERM_W'(9));
    send_op(FN_STABLE, IDX_W'(0), '1);
    send_op(FN_STABLE, IDX_W'(1), TERM_W'(5));
    send_op(FN_QUERY, IDX_W'(0), '0);
    // snapshot near the top of the index space, entries wrap past zero
    send_op(FN_RESTORE, 64'hFFFF_FFFF_FFFF_FFFD, '1);
    send_op(FN_QUERY, 64'hFFFF_FFFF_FFFF_FFFD, '0);
    send_op(FN_APPEND, 64'hFFFF_FFFF_FFFF_FFFE, TERM_W'(3));
    send_op(FN_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, TERM_W'(4));
    send_op(FN_APPEND, IDX_W'(0), TERM_W'(5));
    send_op(FN_QUERY, IDX_W'(0), '0);
    send_op(FN_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_op(FN_STABLE, 64'hFFFF_FFFF_FFFF_FFFE, TERM_W'(3));
    send_op(FN_SNAP_STABLE, 64'hFFFF_FFFF_FFFF_FFFD, '0);
    // snapshot above the entries
    send_op(FN_RESTORE, IDX_W'(100), TERM_W'(2));
    send_op(FN_APPEND, IDX_W'(50), TERM_W'(1));
    send_op(FN_QUERY, IDX_W'(100), '0);
    for (int f = int'(FN_QUERY) + 1; f < (1 << FN_W); f++) begin
      send_op(FN_W'(f), '1, '1);
    end
    send_op(FN_RESTORE, IDX_W'(999), TERM_W'(1));

    sent = 0;
    while (sent < RANDOM_OPS) begin
      phase = sent * 3 / RANDOM_OPS;
      tx_idle_pct <= (phase == 0) ? 19 : (phase == 1) ? 81 : 0;
      rx_idle_pct <= (phase == 0) ? 81 : (phase == 1) ? 19 : 0;
      if (sent == 300 || sent == 760) begin
        fill_ring();
        sent += FILL_RUN;
      end else begin
        random_op();
        sent++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
